// ===== rtl/core/dsa_pkg.sv =====
`timescale 1ns / 1ps

package dsa_pkg;

	// Slot capacity of the allocator and the widths that follow from it.
	localparam int CAPACITY = 1024;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths of the request, result and register port.
	localparam int IDX_W       = 16;
	localparam int SLOT_FLD_W  = 10;
	localparam int FC_FLD_W    = 11;
	localparam int HANDLE_W    = 48;
	localparam int HEAP_W      = 11;
	localparam int STRIDE_W    = 13;
	localparam int CFG_DATA_W  = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int SZ_CMP_W    = (CNT_W > HEAP_W) ? CNT_W : HEAP_W;
	localparam int OFF_W       = SLOT_W + STRIDE_W;

	// Reset values of the configuration registers.
	localparam logic [HEAP_W-1:0]   HEAP_RST   = HEAP_W'(1024);
	localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(32);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHADER_VISIBLE = 3'd4;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_RANGE    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage

// ===== rtl/core/dsa_req_if.sv =====
`timescale 1ns / 1ps

interface dsa_req_if import dsa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [IDX_W-1:0] free_index;

	modport source (output valid, output mode, output free_index, input ready);
	modport sink (input valid, input mode, input free_index, output ready);
endinterface

// ===== rtl/core/dsa_rsp_if.sv =====
`timescale 1ns / 1ps

interface dsa_rsp_if import dsa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	status_t               status;
	logic [SLOT_FLD_W-1:0] slot;
	logic [HANDLE_W-1:0]   cpu_handle;
	logic [HANDLE_W-1:0]   gpu_handle;
	logic [FC_FLD_W-1:0]   free_count;

	modport source (output valid, output status, output slot, output cpu_handle,
		output gpu_handle, output free_count, input ready);
	modport sink (input valid, input status, input slot, input cpu_handle,
		input gpu_handle, input free_count, output ready);
endinterface

// ===== rtl/core/descriptor_slot_allocator.sv =====
`timescale 1ns / 1ps
// Result path: a free or a failed request goes from acceptance through the offset multiply and
// the handle add into the result register; an allocation from the freed-slot stack first passes a RAM read.
// The sequencer handles one item at a time through stack access, offset multiply and handle
// add, and takes no new request until the result register has been loaded, which waits
// for rsp.ready while a previous result is still held.
// Reset: arst_n clears the counters and loads the register defaults; the stack RAM
// is not cleared, since only entries below the freed count are ever read.

module descriptor_slot_allocator import dsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	dsa_req_if.sink               req,
	dsa_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_ADD
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [HEAP_W-1:0]   heap_size_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [HANDLE_W-1:0] cpu_base_q;
	logic [HANDLE_W-1:0] gpu_base_q;
	logic                shader_visible_q;

	// Allocation counters.
	logic [CNT_W-1:0] freed_count_q;
	logic [CNT_W-1:0] next_fresh_q;

	// Per-item working registers.
	logic [SLOT_W-1:0] slot_s1;
	logic              succ_s1;
	status_t           status_s1;
	logic [CNT_W-1:0]  fc_s1;
	logic [OFF_W-1:0]  off_s2;

	// Result register.
	logic                  rsp_valid_q;
	status_t               rsp_status_q;
	logic [SLOT_FLD_W-1:0] rsp_slot_q;
	logic [HANDLE_W-1:0]   rsp_cpu_q;
	logic [HANDLE_W-1:0]   rsp_gpu_q;
	logic [FC_FLD_W-1:0]   rsp_fc_q;

	logic              accept;
	logic              heap_wr;
	logic              rsp_load;
	logic [CNT_W-1:0]  eff_size;
	logic [CNT_W-1:0]  fc_dec;
	logic [CNT_W-1:0]  fc_d;
	logic [CNT_W-1:0]  nf_d;
	logic [CNT_W-1:0]  fc_total;
	logic [SLOT_W-1:0] slot_d;
	logic              succ_d;
	logic              pop_d;
	logic              push_d;
	status_t           status_d;
	logic [SLOT_W-1:0] ram_rdata;
	logic [HANDLE_W-1:0] off_ext;

	assign accept   = req.valid && req.ready;
	assign heap_wr  = cfg_we && (cfg_index == REG_HEAP_SIZE);
	assign rsp_load = (state_q == S_ADD) && (!rsp_valid_q || rsp.ready);
	assign fc_dec   = freed_count_q - CNT_W'(1);
	assign off_ext  = HANDLE_W'(off_s2);

	// Effective heap size is heap_size clamped to the capacity.
	always_comb begin
		if (SZ_CMP_W'(heap_size_q) > SZ_CMP_W'(CAPACITY)) begin
			eff_size = CNT_W'(CAPACITY);
		end else begin
			eff_size = CNT_W'(heap_size_q);
		end
	end

	// Decision for the item at the request port, from the current counters.
	always_comb begin
		fc_d     = freed_count_q;
		nf_d     = next_fresh_q;
		slot_d   = '0;
		succ_d   = 1'b0;
		pop_d    = 1'b0;
		push_d   = 1'b0;
		status_d = ST_OK;
		if (!req.mode) begin
			if (freed_count_q != '0 && CMP_W'(freed_count_q) <= CMP_W'(CAPACITY)) begin
				fc_d   = fc_dec;
				pop_d  = 1'b1;
				succ_d = 1'b1;
			end else if (next_fresh_q < eff_size) begin
				slot_d = next_fresh_q[SLOT_W-1:0];
				nf_d   = next_fresh_q + CNT_W'(1);
				succ_d = 1'b1;
			end else begin
				status_d = ST_EMPTY;
			end
		end else begin
			if (CMP_W'(req.free_index) >= CMP_W'(eff_size)) begin
				status_d = ST_RANGE;
			end else if (freed_count_q >= next_fresh_q ||
				CMP_W'(freed_count_q) >= CMP_W'(CAPACITY)) begin
				status_d = ST_OVERFLOW;
			end else begin
				push_d = 1'b1;
				fc_d   = freed_count_q + CNT_W'(1);
			end
		end
		if (eff_size >= nf_d) begin
			fc_total = fc_d + (eff_size - nf_d);
		end else begin
			fc_total = fc_d;
		end
	end

	// Stack of freed slots: push at the count, pop from the count minus one.
	dsa_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (CAPACITY)
	) u_stack (
		.clk   (clk),
		.we    (accept && push_d),
		.waddr (freed_count_q[SLOT_W-1:0]),
		.wdata (req.free_index[SLOT_W-1:0]),
		.re    (accept && pop_d),
		.raddr (fc_dec[SLOT_W-1:0]),
		.rdata (ram_rdata)
	);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q      <= HEAP_RST;
			stride_q         <= STRIDE_RST;
			cpu_base_q       <= '0;
			gpu_base_q       <= '0;
			shader_visible_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAP_SIZE:      heap_size_q      <= cfg_data[HEAP_W-1:0];
				REG_STRIDE:         stride_q         <= cfg_data[STRIDE_W-1:0];
				REG_CPU_BASE:       cpu_base_q       <= cfg_data[HANDLE_W-1:0];
				REG_GPU_BASE:       gpu_base_q       <= cfg_data[HANDLE_W-1:0];
				REG_SHADER_VISIBLE: shader_visible_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Allocation counters: a heap_size write empties them, an accepted item updates them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freed_count_q <= '0;
			next_fresh_q  <= '0;
		end else if (heap_wr) begin
			freed_count_q <= '0;
			next_fresh_q  <= '0;
		end else if (accept) begin
			freed_count_q <= fc_d;
			next_fresh_q  <= nf_d;
		end
	end

	// Result valid: set when the handle add completes, cleared when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.valid && rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Sequencer: accept, optional stack read, offset multiply, handle add.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						slot_s1   <= slot_d;
						succ_s1   <= succ_d;
						status_s1 <= status_d;
						fc_s1     <= fc_total;
						state_q   <= pop_d ? S_READ : S_MUL;
					end
				end
				S_READ: begin
					slot_s1 <= ram_rdata;
					state_q <= S_MUL;
				end
				S_MUL: begin
					off_s2  <= OFF_W'(slot_s1) * OFF_W'(stride_q);
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (rsp_load) begin
						rsp_status_q <= status_s1;
						rsp_slot_q   <= succ_s1 ? SLOT_FLD_W'(slot_s1) : '0;
						rsp_cpu_q    <= succ_s1 ? (cpu_base_q + off_ext) : '0;
						rsp_gpu_q    <= (succ_s1 && shader_visible_q) ?
							(gpu_base_q + off_ext) : '0;
						rsp_fc_q     <= FC_FLD_W'(fc_s1);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.slot       = rsp_slot_q;
	assign rsp.cpu_handle = rsp_cpu_q;
	assign rsp.gpu_handle = rsp_gpu_q;
	assign rsp.free_count = rsp_fc_q;

`ifndef SYNTHESIS
	// Only one item is in flight: the port closes right after an acceptance.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while another item is in flight");

	// The stack never holds more slots than have been handed out fresh.
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		freed_count_q <= next_fresh_q)
		else $error("freed count exceeds handed-out slots");

	// Fresh slots never run past the effective heap size.
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_fresh_q <= eff_size)
		else $error("next fresh slot beyond heap size");

	// A failed result carries no slot and no handles; a free result is zeroed too, but only failed ones are checked.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |->
			(rsp.slot == '0 && rsp.cpu_handle == '0 && rsp.gpu_handle == '0))
		else $error("error result carries a slot or handle");
`endif

endmodule

// ===== rtl/core/dsa_ram.sv =====
`timescale 1ns / 1ps

module dsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
